// ===== hdl/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared constants, log table, datapath op codes and control structs for the
// binomial change-point search.
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COUNT_BITS = 16;
    localparam int PT_BITS    = $clog2(MAX_POINTS + 1);
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int SUM_BITS   = COUNT_BITS + IDX_BITS;
    localparam int COST_BITS  = 40;
    localparam int MS_BITS    = 5;
    localparam int RATE_BITS  = 17;
    localparam int NUM_BITS   = SUM_BITS + 16;
    localparam int DIV_STEPS  = RATE_BITS;
    localparam int LN_BITS    = 21;
    localparam int TAB_BITS   = 17;

    localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};
    localparam logic [COST_BITS-1:0] COST_MAX = COST_INF - 1'b1;
    localparam logic [15:0]          LN2_Q16  = 16'd45426;
    localparam logic [COST_BITS-1:0] LAMBDA_RESET = 40'd2560;
    localparam logic [MS_BITS-1:0]   MS_RESET     = 5'd3;

    localparam logic CFG_LAMBDA = 1'b0;
    localparam logic CFG_MINSEG = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_READ,
        OP_LATCH_J,
        OP_CAND,
        OP_DIV,
        OP_LN_IN,
        OP_LN_S2,
        OP_LN_S3,
        OP_LN_OUT,
        OP_MUL,
        OP_COST,
        OP_TOTAL,
        OP_JEND,
        OP_STK_CUT,
        OP_STK_ZERO,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                sel;
        logic [PT_BITS-1:0]  addr;
        logic [IDX_BITS-1:0] seg_first;
        logic [IDX_BITS-1:0] seg_last;
        logic                eol;
    } cmd_t;

    typedef struct packed {
        logic                div_busy;
        logic                skip;
        logic                zero;
        logic                over_inf;
        logic [PT_BITS-1:0]  cut_rd;
        logic [IDX_BITS-1:0] stack_rd;
    } st_t;

    function automatic logic [TAB_BITS-1:0] log2_tab(input logic [4:0] idx);
        logic [TAB_BITS-1:0] v;
        case (idx)
            5'd0:  v = 17'd0;
            5'd1:  v = 17'd5732;
            5'd2:  v = 17'd11136;
            5'd3:  v = 17'd16248;
            5'd4:  v = 17'd21098;
            5'd5:  v = 17'd25711;
            5'd6:  v = 17'd30110;
            5'd7:  v = 17'd34312;
            5'd8:  v = 17'd38336;
            5'd9:  v = 17'd42196;
            5'd10: v = 17'd45904;
            5'd11: v = 17'd49472;
            5'd12: v = 17'd52911;
            5'd13: v = 17'd56228;
            5'd14: v = 17'd59434;
            5'd15: v = 17'd62534;
            5'd16: v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/bcd_div.sv =====
// ----------------------------------------------------------------------------
// bcd_div
// Restoring divider, one quotient bit per cycle, for the rounded segment rate.
// ----------------------------------------------------------------------------
module bcd_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bcd_pkg::NUM_BITS-1:0]  num,
    input  logic [bcd_pkg::SUM_BITS-1:0]  den,
    output logic [bcd_pkg::RATE_BITS-1:0] quo,
    output logic                          busy
);
    import bcd_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_STEPS + 1);

    logic [SUM_BITS:0]    rem_reg, rem_next;
    logic [RATE_BITS-1:0] nsh_reg, nsh_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [SUM_BITS:0]    trial;
    logic                 ge;

    always_comb begin
        trial     = {rem_reg[SUM_BITS-1:0], nsh_reg[RATE_BITS-1]};
        ge        = trial >= {1'b0, den};
        rem_next  = rem_reg;
        nsh_next  = nsh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = (SUM_BITS + 1)'(num[NUM_BITS-1:RATE_BITS]);
            nsh_next  = num[RATE_BITS-1:0];
            cnt_next  = CNT_BITS'(DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? trial - {1'b0, den} : trial;
            nsh_next  = {nsh_reg[RATE_BITS-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = cnt_reg != CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        nsh_reg <= nsh_next;
    end

    assign quo  = nsh_reg;
    assign busy = busy_reg;

endmodule

// ===== hdl/bcd_dp.sv =====
// ----------------------------------------------------------------------------
// bcd_dp
// Datapath: prefix, cost, cut and stack memories, segment cost arithmetic
// (divider, table log, multipliers) and the output word register.
// ----------------------------------------------------------------------------
module bcd_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bcd_pkg::cmd_t                  cmd,
    output bcd_pkg::st_t                   st,
    input  logic [bcd_pkg::COUNT_BITS-1:0] in_death,
    input  logic [bcd_pkg::COUNT_BITS-1:0] in_at_risk,
    input  logic [bcd_pkg::COST_BITS-1:0]  lambda,
    output logic [bcd_pkg::IDX_BITS-1:0]   out_first,
    output logic [bcd_pkg::IDX_BITS-1:0]   out_last,
    output logic [bcd_pkg::RATE_BITS-1:0]  out_rate,
    output logic                           out_found,
    output logic [bcd_pkg::COST_BITS-1:0]  out_cost,
    output logic                           out_eol
);
    import bcd_pkg::*;

    logic [SUM_BITS-1:0]  mem_d     [0:MAX_POINTS];
    logic [SUM_BITS-1:0]  mem_p     [0:MAX_POINTS];
    logic [COST_BITS-1:0] mem_cost  [0:MAX_POINTS];
    logic [PT_BITS-1:0]   mem_cut   [0:MAX_POINTS];
    logic [IDX_BITS-1:0]  mem_stack [0:MAX_POINTS-1];

    logic [SUM_BITS-1:0]  sum_d_reg, sum_p_reg;
    logic [SUM_BITS-1:0]  rd_d_reg, rd_p_reg;
    logic [COST_BITS-1:0] rd_cost_reg;
    logic [PT_BITS-1:0]   rd_cut_reg;
    logic [IDX_BITS-1:0]  rd_stack_reg;
    logic                 rdz_reg;
    logic [SUM_BITS-1:0]  rd_d, rd_p;
    logic [COST_BITS-1:0] rd_cost;

    logic [SUM_BITS-1:0]  pj_d_reg, pj_p_reg, d_reg, p_reg;
    logic [COST_BITS-1:0] bci_reg, c_reg, bestj_reg, over_reg;
    logic [PT_BITS-1:0]   cutj_reg;

    logic [RATE_BITS-1:0] quo, rate, ln_x;
    logic                 div_busy;
    logic [15:0]          x16, ln_m;
    logic [3:0]           lead, ln_b_reg;
    logic [3:0]           ln_idx_reg;
    logic [10:0]          ln_rem_reg;
    logic [TAB_BITS-1:0]  ln_lf_reg, tab_lo, tab_hi;
    logic [27:0]          ln_ip;
    logic [LN_BITS-1:0]   ln_n2;
    logic [LN_BITS+15:0]  ln_prod_reg;
    logic [LN_BITS-1:0]   l1_reg, l2_reg, ln_l;
    logic [SUM_BITS+LN_BITS-1:0] mul1_reg, mul2_reg;
    logic [SUM_BITS+LN_BITS+2:0] acc;
    logic [SUM_BITS+LN_BITS+2:0] cost_full;
    logic [COST_BITS+1:0] tot_full;
    logic [COST_BITS-1:0] tot;

    bcd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == OP_DIV),
        .num     ({d_reg, 16'd0} + NUM_BITS'(p_reg >> 1)),
        .den     (p_reg),
        .quo     (quo),
        .busy    (div_busy)
    );

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            mem_d[cmd.addr] <= sum_d_reg + SUM_BITS'(in_death);
            mem_p[cmd.addr] <= sum_p_reg + SUM_BITS'(in_at_risk);
        end
        if (cmd.op == OP_JEND) begin
            mem_cost[cmd.addr] <= bestj_reg;
            mem_cut[cmd.addr]  <= cutj_reg;
        end
        if (cmd.op == OP_STK_CUT) begin
            mem_stack[cmd.addr[IDX_BITS-1:0]] <= rd_cut_reg[IDX_BITS-1:0];
        end
        if (cmd.op == OP_STK_ZERO) begin
            mem_stack[cmd.addr[IDX_BITS-1:0]] <= '0;
        end
        if (cmd.op == OP_READ) begin
            rd_d_reg     <= mem_d[cmd.addr];
            rd_p_reg     <= mem_p[cmd.addr];
            rd_cost_reg  <= mem_cost[cmd.addr];
            rd_cut_reg   <= mem_cut[cmd.addr];
            rd_stack_reg <= mem_stack[cmd.addr[IDX_BITS-1:0]];
            rdz_reg      <= cmd.addr == '0;
        end
    end

    // entry zero of the prefix and cost tables is always zero
    assign rd_d    = rdz_reg ? '0 : rd_d_reg;
    assign rd_p    = rdz_reg ? '0 : rd_p_reg;
    assign rd_cost = rdz_reg ? '0 : rd_cost_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_d_reg <= '0;
            sum_p_reg <= '0;
        end else if (cmd.op == OP_LOAD) begin
            sum_d_reg <= sum_d_reg + SUM_BITS'(in_death);
            sum_p_reg <= sum_p_reg + SUM_BITS'(in_at_risk);
        end else if (cmd.op == OP_CLEAR) begin
            sum_d_reg <= '0;
            sum_p_reg <= '0;
        end
    end

    // log unit, -ln(x/65536) in q.16
    assign ln_x = cmd.sel ? RATE_BITS'(17'd65536 - quo) : quo;

    always_comb begin
        if (ln_x == '0) begin
            x16 = 16'd1;
        end else if (ln_x[RATE_BITS-1]) begin
            x16 = 16'hffff;
        end else begin
            x16 = ln_x[15:0];
        end
        lead = '0;
        for (int k = 0; k < 16; k++) begin
            if (x16[k]) lead = 4'(k);
        end
        ln_m   = x16 << (4'd15 - lead);
        tab_lo = log2_tab({1'b0, ln_idx_reg});
        tab_hi = log2_tab(5'({1'b0, ln_idx_reg}) + 5'd1);
        ln_ip  = 28'(tab_hi - tab_lo) * 28'(ln_rem_reg) + 28'd1024;
        ln_n2  = (LN_BITS'(5'd16 - {1'b0, ln_b_reg}) << 16) - LN_BITS'(ln_lf_reg);
        ln_l   = LN_BITS'((ln_prod_reg + (LN_BITS + 16)'(32768)) >> 16);
    end

    assign rate = (p_reg == '0) ? '0 :
                  (d_reg >= p_reg) ? RATE_BITS'(17'd65536) : quo;

    always_comb begin
        acc       = (SUM_BITS + LN_BITS + 3)'(mul1_reg) + (SUM_BITS + LN_BITS + 3)'(mul2_reg);
        cost_full = ((acc << 1) + (SUM_BITS + LN_BITS + 3)'(128)) >> 8;
        tot_full  = (COST_BITS + 2)'(bci_reg) + (COST_BITS + 2)'(c_reg)
                  + (COST_BITS + 2)'(lambda);
        tot       = (tot_full > (COST_BITS + 2)'(COST_MAX)) ? COST_MAX
                                                          : tot_full[COST_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LATCH_J: begin
                pj_d_reg  <= rd_d;
                pj_p_reg  <= rd_p;
                bestj_reg <= COST_INF;
                cutj_reg  <= '0;
            end
            OP_CAND: begin
                d_reg   <= pj_d_reg - rd_d;
                p_reg   <= pj_p_reg - rd_p;
                bci_reg <= rd_cost;
                c_reg   <= '0;
            end
            OP_LN_IN: begin
                ln_b_reg   <= lead;
                ln_idx_reg <= ln_m[14:11];
                ln_rem_reg <= ln_m[10:0];
            end
            OP_LN_S2: begin
                ln_lf_reg <= tab_lo + TAB_BITS'(ln_ip >> 11);
            end
            OP_LN_S3: begin
                ln_prod_reg <= (LN_BITS + 16)'(ln_n2) * (LN_BITS + 16)'(LN2_Q16);
            end
            OP_LN_OUT: begin
                if (cmd.sel) begin
                    l2_reg <= ln_l;
                end else begin
                    l1_reg <= ln_l;
                end
            end
            OP_MUL: begin
                mul1_reg <= (SUM_BITS + LN_BITS)'(d_reg) * (SUM_BITS + LN_BITS)'(l1_reg);
                mul2_reg <= (SUM_BITS + LN_BITS)'(p_reg - d_reg)
                          * (SUM_BITS + LN_BITS)'(l2_reg);
            end
            OP_COST: begin
                c_reg <= (cost_full > (SUM_BITS + LN_BITS + 3)'(COST_MAX)) ? COST_MAX
                                                         : COST_BITS'(cost_full);
            end
            OP_TOTAL: begin
                if (tot < bestj_reg) begin
                    bestj_reg <= tot;
                    cutj_reg  <= cmd.addr;
                end
            end
            OP_JEND: begin
                over_reg <= bestj_reg;
            end
            OP_EMIT: begin
                out_first <= cmd.seg_first;
                out_last  <= cmd.seg_last;
                out_rate  <= rate;
                out_found <= over_reg != COST_INF;
                out_cost  <= over_reg;
                out_eol   <= cmd.eol;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        st.div_busy = div_busy;
        st.skip     = (bci_reg == COST_INF) ||
                      ((p_reg != '0) && ((d_reg == '0) || (d_reg >= p_reg)));
        st.zero     = p_reg == '0;
        st.over_inf = over_reg == COST_INF;
        st.cut_rd   = rd_cut_reg;
        st.stack_rd = rd_stack_reg;
    end

endmodule

// ===== hdl/bcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcd_ctrl
// Controller: load counting, partition search loops, backtracking and
// segment output sequencing.
// ----------------------------------------------------------------------------
module bcd_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tlast,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [bcd_pkg::MS_BITS-1:0] min_segment,
    output bcd_pkg::cmd_t               cmd,
    input  bcd_pkg::st_t                st
);
    import bcd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE, ST_J_RD, ST_J_LAT, ST_I_RD, ST_I_CAND, ST_I_CHK, ST_DIV_GO,
        ST_DIV_W, ST_LN1, ST_LN2, ST_LN3, ST_LN4, ST_MUL, ST_COST, ST_TOT,
        ST_I_NXT, ST_J_END, ST_BT_START, ST_BT_RD, ST_BT_WR, ST_O_START,
        ST_O_RDF, ST_O_LATF, ST_O_RDN, ST_O_LATN, ST_O_RDP, ST_O_LJ, ST_O_RDI,
        ST_O_CI, ST_O_DIVG, ST_O_DIVW, ST_O_EMIT, ST_O_HOLD, ST_FIN
    } state_t;

    state_t              state_reg;
    logic [PT_BITS-1:0]  n_reg, j_reg, i_reg, pos_reg, cnt_reg;
    logic [IDX_BITS-1:0] idx_reg, first_reg, last_reg;
    logic                ln_sel_reg;
    logic [MS_BITS-1:0]  ms;
    logic                full;
    logic                i_fits_next;

    assign ms          = (min_segment == '0) ? MS_BITS'(1) : min_segment;
    assign full        = n_reg == PT_BITS'(MAX_POINTS);
    assign i_fits_next = (PT_BITS + 1)'(i_reg) + (PT_BITS + 1)'(1) + (PT_BITS + 1)'(ms)
                         <= (PT_BITS + 1)'(j_reg);
    assign s_tready    = state_reg == ST_IDLE;
    assign m_tvalid    = state_reg == ST_O_HOLD;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            n_reg      <= '0;
            j_reg      <= '0;
            i_reg      <= '0;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            first_reg  <= '0;
            last_reg   <= '0;
            ln_sel_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (!full) n_reg <= n_reg + 1'b1;
                        if (s_tlast) begin
                            j_reg     <= PT_BITS'(1);
                            state_reg <= ST_J_RD;
                        end
                    end
                end
                ST_J_RD: state_reg <= ST_J_LAT;
                ST_J_LAT: begin
                    i_reg <= '0;
                    if ((PT_BITS + 1)'(ms) > (PT_BITS + 1)'(j_reg)) begin
                        state_reg <= ST_J_END;
                    end else begin
                        state_reg <= ST_I_RD;
                    end
                end
                ST_I_RD:   state_reg <= ST_I_CAND;
                ST_I_CAND: state_reg <= ST_I_CHK;
                ST_I_CHK: begin
                    if (st.skip) begin
                        state_reg <= ST_I_NXT;
                    end else if (st.zero) begin
                        state_reg <= ST_TOT;
                    end else begin
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: state_reg <= ST_DIV_W;
                ST_DIV_W: begin
                    ln_sel_reg <= 1'b0;
                    if (!st.div_busy) state_reg <= ST_LN1;
                end
                ST_LN1: state_reg <= ST_LN2;
                ST_LN2: state_reg <= ST_LN3;
                ST_LN3: state_reg <= ST_LN4;
                ST_LN4: begin
                    if (ln_sel_reg) begin
                        state_reg <= ST_MUL;
                    end else begin
                        ln_sel_reg <= 1'b1;
                        state_reg  <= ST_LN1;
                    end
                end
                ST_MUL:  state_reg <= ST_COST;
                ST_COST: state_reg <= ST_TOT;
                ST_TOT:  state_reg <= ST_I_NXT;
                ST_I_NXT: begin
                    if (i_fits_next) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_I_RD;
                    end else begin
                        state_reg <= ST_J_END;
                    end
                end
                ST_J_END: begin
                    if (j_reg == n_reg) begin
                        state_reg <= ST_BT_START;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_J_RD;
                    end
                end
                ST_BT_START: begin
                    if (st.over_inf) begin
                        cnt_reg   <= PT_BITS'(1);
                        state_reg <= ST_O_START;
                    end else begin
                        cnt_reg   <= '0;
                        pos_reg   <= n_reg;
                        state_reg <= ST_BT_RD;
                    end
                end
                ST_BT_RD: state_reg <= ST_BT_WR;
                ST_BT_WR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    pos_reg <= st.cut_rd;
                    if (st.cut_rd == '0) begin
                        state_reg <= ST_O_START;
                    end else begin
                        state_reg <= ST_BT_RD;
                    end
                end
                ST_O_START: begin
                    idx_reg   <= IDX_BITS'(cnt_reg - 1'b1);
                    state_reg <= ST_O_RDF;
                end
                ST_O_RDF: state_reg <= ST_O_LATF;
                ST_O_LATF: begin
                    first_reg <= st.stack_rd;
                    state_reg <= ST_O_RDN;
                end
                ST_O_RDN: begin
                    if (idx_reg == '0) begin
                        last_reg  <= IDX_BITS'(n_reg - 1'b1);
                        state_reg <= ST_O_RDP;
                    end else begin
                        state_reg <= ST_O_LATN;
                    end
                end
                ST_O_LATN: begin
                    last_reg  <= st.stack_rd - 1'b1;
                    state_reg <= ST_O_RDP;
                end
                ST_O_RDP:  state_reg <= ST_O_LJ;
                ST_O_LJ:   state_reg <= ST_O_RDI;
                ST_O_RDI:  state_reg <= ST_O_CI;
                ST_O_CI:   state_reg <= ST_O_DIVG;
                ST_O_DIVG: state_reg <= ST_O_DIVW;
                ST_O_DIVW: begin
                    if (!st.div_busy) state_reg <= ST_O_EMIT;
                end
                ST_O_EMIT: state_reg <= ST_O_HOLD;
                ST_O_HOLD: begin
                    if (m_tready) begin
                        if (idx_reg == '0) begin
                            state_reg <= ST_FIN;
                        end else begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= ST_O_RDF;
                        end
                    end
                end
                ST_FIN: begin
                    n_reg     <= '0;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd.op        = OP_NONE;
        cmd.sel       = ln_sel_reg;
        cmd.addr      = '0;
        cmd.seg_first = first_reg;
        cmd.seg_last  = last_reg;
        cmd.eol       = idx_reg == '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !full) begin
                    cmd.op   = OP_LOAD;
                    cmd.addr = n_reg + 1'b1;
                end
            end
            ST_J_RD:     begin cmd.op = OP_READ; cmd.addr = j_reg; end
            ST_J_LAT:    cmd.op = OP_LATCH_J;
            ST_I_RD:     begin cmd.op = OP_READ; cmd.addr = i_reg; end
            ST_I_CAND:   cmd.op = OP_CAND;
            ST_DIV_GO:   cmd.op = OP_DIV;
            ST_LN1:      cmd.op = OP_LN_IN;
            ST_LN2:      cmd.op = OP_LN_S2;
            ST_LN3:      cmd.op = OP_LN_S3;
            ST_LN4:      cmd.op = OP_LN_OUT;
            ST_MUL:      cmd.op = OP_MUL;
            ST_COST:     cmd.op = OP_COST;
            ST_TOT:      begin cmd.op = OP_TOTAL; cmd.addr = i_reg; end
            ST_J_END:    begin cmd.op = OP_JEND; cmd.addr = j_reg; end
            ST_BT_START: begin
                if (st.over_inf) cmd.op = OP_STK_ZERO;
            end
            ST_BT_RD:    begin cmd.op = OP_READ; cmd.addr = pos_reg; end
            ST_BT_WR:    begin cmd.op = OP_STK_CUT; cmd.addr = cnt_reg; end
            ST_O_RDF:    begin cmd.op = OP_READ; cmd.addr = PT_BITS'(idx_reg); end
            ST_O_RDN: begin
                if (idx_reg != '0) begin
                    cmd.op   = OP_READ;
                    cmd.addr = PT_BITS'(idx_reg - 1'b1);
                end
            end
            ST_O_RDP: begin
                cmd.op   = OP_READ;
                cmd.addr = PT_BITS'(last_reg) + 1'b1;
            end
            ST_O_LJ:     cmd.op = OP_LATCH_J;
            ST_O_RDI:    begin cmd.op = OP_READ; cmd.addr = PT_BITS'(first_reg); end
            ST_O_CI:     cmd.op = OP_CAND;
            ST_O_DIVG:   cmd.op = OP_DIV;
            ST_O_EMIT:   cmd.op = OP_EMIT;
            ST_FIN:      cmd.op = OP_CLEAR;
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/binomial_changepoint_dp.sv =====
// ----------------------------------------------------------------------------
// binomial_changepoint_dp
// Binomial change-point search by optimal partitioning over loaded points.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one word per observation, tlast marks the final one. each
//   word is stored as prefix sums; words beyond 64 are dropped.
//   the final word starts the search, s_tready stays low until the answer
//   has been delivered.
//   search: each candidate segment waits on the bit-serial rate divider and
//   passes twice through the shared table log unit; a skipped candidate and
//   one with zero at-risk total bypass the divider and the log unit. there
//   are about (n-min_segment+1)^2/2 candidates for n points.
//   backtracking reads one cut per segment, then each segment word is built
//   from prefix reads and one division.
//   m_ channel: one word per segment, first to last, tlast on the final one.
//   a stalled word holds until m_tready; the next segment is built only
//   after the handshake.
//   cfg port: writes are taken at any time, meant for an idle block.
//   reset: synchronous, clears the point count and sums, lambda 2560 and
//   min_segment 3; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module binomial_changepoint_dp (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // death_count, at_risk_count
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // seg_first, seg_last, seg_rate, overall_cost
    output logic [0:0]  m_tuser,   // found_by_search
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [39:0] cfg_wdata
);
    import bcd_pkg::*;

    logic [COST_BITS-1:0] lambda_reg;
    logic [MS_BITS-1:0]   min_seg_reg;
    cmd_t                 cmd;
    st_t                  st;
    logic [IDX_BITS-1:0]  out_first, out_last;
    logic [RATE_BITS-1:0] out_rate;
    logic                 out_found, out_eol;
    logic [COST_BITS-1:0] out_cost;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lambda_reg  <= LAMBDA_RESET;
            min_seg_reg <= MS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index[0])
                CFG_LAMBDA: lambda_reg  <= cfg_wdata[COST_BITS-1:0];
                CFG_MINSEG: min_seg_reg <= cfg_wdata[MS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    bcd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tlast     (s_tlast),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .min_segment (min_seg_reg),
        .cmd         (cmd),
        .st          (st)
    );

    bcd_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .st         (st),
        .in_death   (s_tdata[15:0]),
        .in_at_risk (s_tdata[31:16]),
        .lambda     (lambda_reg),
        .out_first  (out_first),
        .out_last   (out_last),
        .out_rate   (out_rate),
        .out_found  (out_found),
        .out_cost   (out_cost),
        .out_eol    (out_eol)
    );

    assign m_tdata = {3'b000, out_cost, out_rate, out_last, out_first};
    assign m_tuser = out_found;
    assign m_tlast = out_eol;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a segment word is shown");

    a_seg_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] <= m_tdata[11:6]))
        else $error("segment first index beyond last index");

    a_fallback_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[68:29] == COST_INF))
        else $error("fallback segment without infinite cost");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binomial change-point search. Series of
// observations go in on the s_ stream, and a scoreboard with its own
// partitioning predictor checks every segment word that comes out on the
// m_ stream. It covers register settings at their extremes, buffer
// overflow, infeasible series and random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import bcd_pkg::*;

    localparam int LIMIT = 3000000;

    typedef struct packed {
        bit [5:0]  first;
        bit [5:0]  last;
        bit [16:0] rate;
        bit        found;
        bit [39:0] cost;
        bit        eol;
    } seg_word_t;

    class seg_scoreboard;
        bit [39:0]       lambda;
        bit [4:0]        min_seg;
        longint unsigned dsum[65];
        longint unsigned psum[65];
        longint unsigned bcost[65];
        int              bcut[65];
        int              loaded;
        longint unsigned ln_tab[17];
        seg_word_t       want_q[$];
        int              errors;
        int              words_in;
        int              segs_out;
        int              answers;
        int              fallbacks;

        function new();
            ln_tab = '{0, 5732, 11136, 16248, 21098, 25711, 30110, 34312, 38336,
                       42196, 45904, 49472, 52911, 56228, 59434, 62534, 65536};
            lambda  = LAMBDA_RESET;
            min_seg = MS_RESET;
            loaded  = 0;
            dsum[0] = 0;
            psum[0] = 0;
        endfunction

        function void write_reg(bit idx, bit [39:0] v);
            if (idx == CFG_LAMBDA) lambda = v;
            else min_seg = v[4:0];
        endfunction

        // -ln(x/65536) in q.16
        function longint unsigned neg_ln(longint unsigned x);
            int              b;
            longint unsigned m, f, idx, rem, lf, n2;
            if (x == 0) x = 1;
            if (x > 65535) x = 65535;
            b = 15;
            while (b > 0 && x[b] == 1'b0) b--;
            m   = x << (15 - b);
            f   = m - 32768;
            idx = f >> 11;
            rem = f & 2047;
            lf  = ln_tab[idx] + (((ln_tab[idx+1] - ln_tab[idx]) * rem + 1024) >> 11);
            n2  = (16 - b) * 65536 - lf;
            return (n2 * 45426 + 32768) >> 16;
        endfunction

        function longint unsigned rate_of(longint unsigned d, longint unsigned p);
            if (p == 0) return 0;
            if (d >= p) return 65536;
            return ((d << 16) + (p >> 1)) / p;
        endfunction

        function longint unsigned seg_cost(longint unsigned d, longint unsigned p);
            longint unsigned r, acc, c;
            if (p == 0) return 0;
            if (d == 0 || d >= p) return COST_INF;
            r = rate_of(d, p);
            if (r < 1) r = 1;
            if (r > 65535) r = 65535;
            acc = 2 * (d * neg_ln(r) + (p - d) * neg_ln(65536 - r));
            c = (acc + 128) >> 8;
            return (c > COST_MAX) ? COST_MAX : c;
        endfunction

        function void note_input(bit [15:0] d, bit [15:0] p, bit fin);
            int              n, ms, cnt, pos, first, lastp;
            longint unsigned c, total;
            int              stack[64];
            bit              ok;
            seg_word_t       w;
            words_in++;
            if (loaded < MAX_POINTS) begin
                dsum[loaded+1] = dsum[loaded] + d;
                psum[loaded+1] = psum[loaded] + p;
                loaded++;
            end
            if (!fin) return;
            n  = loaded;
            ms = (min_seg == 0) ? 1 : min_seg;
            bcost[0] = 0;
            bcut[0]  = 0;
            for (int j = 1; j <= n; j++) begin
                bcost[j] = COST_INF;
                bcut[j]  = 0;
                for (int i = 0; i + ms <= j; i++) begin
                    if (bcost[i] == COST_INF) continue;
                    c = seg_cost(dsum[j] - dsum[i], psum[j] - psum[i]);
                    if (c == COST_INF) continue;
                    total = bcost[i] + c + lambda;
                    if (total > COST_MAX) total = COST_MAX;
                    if (total < bcost[j]) begin
                        bcost[j] = total;
                        bcut[j]  = i;
                    end
                end
            end
            ok  = (bcost[n] != COST_INF);
            cnt = 0;
            if (ok) begin
                pos = n;
                while (pos > 0 && cnt < 64) begin
                    stack[cnt++] = bcut[pos];
                    pos = bcut[pos];
                end
            end else begin
                stack[cnt++] = 0;
                fallbacks++;
            end
            for (int k = 0; k < cnt; k++) begin
                first = stack[cnt-1-k];
                lastp = (k + 1 == cnt) ? n - 1 : stack[cnt-2-k] - 1;
                w.first = 6'(first);
                w.last  = 6'(lastp);
                w.rate  = 17'(rate_of(dsum[lastp+1] - dsum[first],
                                      psum[lastp+1] - psum[first]));
                w.found = ok;
                w.cost  = 40'(bcost[n]);
                w.eol   = (k + 1 == cnt);
                want_q  = {want_q, w};
            end
            answers++;
            loaded = 0;
        endfunction

        function void check_result(bit [71:0] data, bit user, bit lst);
            seg_word_t w, g;
            g.first = data[5:0];
            g.last  = data[11:6];
            g.rate  = data[28:12];
            g.cost  = data[68:29];
            g.found = user;
            g.eol   = lst;
            segs_out++;
            if (want_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected segment word first=%0d last=%0d",
                                           g.first, g.last);
                return;
            end
            w = want_q.pop_front();
            if (w != g || data[71:69] != 0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %0d..%0d r=%0d f=%0d c=%0h e=%0d, got %0d..%0d r=%0d f=%0d c=%0h e=%0d",
                             w.first, w.last, w.rate, w.found, w.cost, w.eol,
                             g.first, g.last, g.rate, g.found, g.cost, g.eol);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [39:0] cfg_wdata = '0;

    seg_scoreboard sb = new();
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_cnt = 0;
    int cyc = 0;

    always #6 aclk = ~aclk;

    binomial_changepoint_dp i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // receiver stalls, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            m_tready = 1'b0;
            hold_cnt = hold_cnt - 1;
        end else begin
            m_tready = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0], m_tlast);
    end

    always @(posedge aclk) begin
        cyc = cyc + 1;
        if (cyc > LIMIT) begin
            $display("FAIL binomial_changepoint_dp");
            $finish;
        end
    end

    task automatic send_word(bit [15:0] d, bit [15:0] p, bit fin);
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {p, d};
        s_tlast  = fin;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(d, p, fin);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // mostly rates with a few level shifts, some noise words
    task automatic send_series(int n, int noise_pct);
        int          lvl;
        int unsigned p, d;
        lvl = $urandom_range(20, 980);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) lvl = $urandom_range(20, 980);
            if ($urandom_range(99) < noise_pct) begin
                p = $urandom_range(65535);
                d = $urandom_range(65535);
            end else begin
                p = ($urandom_range(3) == 0) ? $urandom_range(65535, 2) : $urandom_range(2000, 2);
                d = p * lvl / 1000;
                if (d < 1) d = 1;
                if (d > p - 1) d = p - 1;
            end
            send_word(16'(d), 16'(p), k == n - 1);
        end
    endtask

    task automatic drain();
        while (sb.want_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(bit idx, bit [39:0] v);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        sb.write_reg(idx, v);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes and special cases, default registers, then lambda 0 and min_segment 1
        send_word(16'd0, 16'd0, 1'b1);
        send_word(16'hFFFF, 16'hFFFF, 1'b0);
        send_word(16'd0, 16'hFFFF, 1'b0);
        send_word(16'hFFFF, 16'd1, 1'b1);
        send_word(16'd1, 16'hFFFF, 1'b0);
        send_word(16'h7FFF, 16'hFFFF, 1'b0);
        send_word(16'hFFFE, 16'hFFFF, 1'b0);
        send_word(16'd0, 16'd0, 1'b0);
        send_word(16'd5, 16'd10, 1'b0);
        send_word(16'd5, 16'd10, 1'b1);
        send_series(6, 0);
        drain();
        write_reg(CFG_LAMBDA, 40'd0);
        write_reg(CFG_MINSEG, 40'd1);
        send_series(7, 0);
        send_word(16'd3, 16'd100, 1'b0);
        send_word(16'd3, 16'd100, 1'b0);
        send_word(16'd3, 16'd100, 1'b1);
        drain();

        // overflow: words beyond the buffer are dropped; then min_segment 31 on a short series
        write_reg(CFG_LAMBDA, 40'hFF_FFFF_FFFF);
        write_reg(CFG_MINSEG, 40'd16);
        send_series(70, 0);
        drain();
        write_reg(CFG_MINSEG, 40'd31);
        send_series(5, 0);
        drain();
        write_reg(CFG_MINSEG, 40'd0);
        write_reg(CFG_LAMBDA, 40'd512);

        // random series under three stall profiles
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 76 : 0;
            rcv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 26 : 0;
            for (int s = 0; s < 5; s++) begin
                if (ph == 2 && s == 1) begin
                    @(posedge aclk);
                    hold_cnt = 3000;
                    send_series(8, 5);
                end
                send_series($urandom_range(4, 1), 10);
            end
            drain();
            write_reg(CFG_LAMBDA,
                      40'({$urandom_range(255), $urandom()} >> $urandom_range(39)));
            write_reg(CFG_MINSEG, 40'($urandom_range(5, 1)));
        end
        send_series(4, 100);
        drain();

        $display("covered %0d input words, %0d answers (%0d fallback), %0d segment words",
                 sb.words_in, sb.answers, sb.fallbacks, sb.segs_out);
        if (sb.errors == 0) begin
            $display("PASS binomial_changepoint_dp");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAIL binomial_changepoint_dp");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bcd_pkg.sv
hdl/bcd_div.sv
hdl/bcd_dp.sv
hdl/bcd_ctrl.sv
hdl/binomial_changepoint_dp.sv
sim/tb_top.sv
